// File: hw/rtl/trs_hierarchy_point_transform_core_macros.svh
// Assertion macros used by the checker file.
// No dependencies; the including scope provides clk and rst.
`ifndef TRS_HIERARCHY_POINT_TRANSFORM_CORE_MACROS_SVH
`define TRS_HIERARCHY_POINT_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication
`define TRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/trs_pkg.sv
// Types, constants and the step table of the hierarchy point transform core.
// No dependencies.
package trs_pkg;

  localparam int POS_FRAC_BITS = 24;
  localparam int PT_W  = 48;
  localparam int Q_W   = 32;
  localparam int LIM_W = 23;
  localparam int OPA_W = 56;
  localparam int ACC_W = 64;

  localparam logic signed [Q_W-1:0] QUAT_ONE = 32'sh4000_0000;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 23'd1000000;

  localparam logic signed [ACC_W-1:0] P48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] P48_MIN = 64'shFFFF_8000_0000_0000;
  localparam logic signed [ACC_W-1:0] Q32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] Q32_MIN = 64'shFFFF_FFFF_8000_0000;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  localparam logic [0:0] REG_LIMIT_ADDR = 1'b0;

  localparam logic [3:0] A_PT0 = 4'd0;
  localparam logic [3:0] A_PT1 = 4'd1;
  localparam logic [3:0] A_PT2 = 4'd2;
  localparam logic [3:0] A_P0  = 4'd3;
  localparam logic [3:0] A_P1  = 4'd4;
  localparam logic [3:0] A_P2  = 4'd5;
  localparam logic [3:0] A_UV0 = 4'd6;
  localparam logic [3:0] A_UV1 = 4'd7;
  localparam logic [3:0] A_UV2 = 4'd8;
  localparam logic [3:0] A_Q0  = 4'd9;
  localparam logic [3:0] A_Q1  = 4'd10;
  localparam logic [3:0] A_Q2  = 4'd11;
  localparam logic [3:0] A_Q3  = 4'd12;

  localparam logic [3:0] B_S0 = 4'd0;
  localparam logic [3:0] B_S1 = 4'd1;
  localparam logic [3:0] B_S2 = 4'd2;
  localparam logic [3:0] B_Q0 = 4'd3;
  localparam logic [3:0] B_Q1 = 4'd4;
  localparam logic [3:0] B_Q2 = 4'd5;
  localparam logic [3:0] B_Q3 = 4'd6;
  localparam logic [3:0] B_C0 = 4'd7;
  localparam logic [3:0] B_C1 = 4'd8;
  localparam logic [3:0] B_C2 = 4'd9;
  localparam logic [3:0] B_C3 = 4'd10;

  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_P    = 3'd1;
  localparam logic [2:0] DST_UV   = 3'd2;
  localparam logic [2:0] DST_UUV  = 3'd3;
  localparam logic [2:0] DST_PT   = 3'd4;
  localparam logic [2:0] DST_R    = 3'd5;

  localparam int NUM_STEPS = 34;
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic              command;
    logic signed [47:0] trans_x;
    logic signed [47:0] trans_y;
    logic signed [47:0] trans_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic              last;
  } item_t;

  typedef struct packed {
    logic signed [47:0] world_x;
    logic signed [47:0] world_y;
    logic signed [47:0] world_z;
    logic signed [31:0] rot_w;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic              abnormal;
  } result_t;

  typedef struct packed {
    logic [3:0] asel;
    logic [3:0] bsel;
    logic       sh24;
    logic       sub;
    logic       first;
    logic [2:0] dst;
    logic [1:0] didx;
  } uop_t;

  typedef struct packed {
    logic                    start;
    logic                    sh24;
    logic signed [OPA_W-1:0] a;
    logic signed [Q_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] m;
  } mul_rsp_t;

  function automatic uop_t mk(input logic [3:0] a, input logic [3:0] b, input logic sh,
                              input logic sub, input logic first, input logic [2:0] dst,
                              input logic [1:0] didx);
    uop_t u;
    u.asel  = a;
    u.bsel  = b;
    u.sh24  = sh;
    u.sub   = sub;
    u.first = first;
    u.dst   = dst;
    u.didx  = didx;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [STEP_W-1:0] idx);
    uop_t u;
    case (idx)
      6'd0:  u = mk(A_PT0, B_S0, 1'b1, 1'b0, 1'b1, DST_P,    2'd0);
      6'd1:  u = mk(A_PT1, B_S1, 1'b1, 1'b0, 1'b1, DST_P,    2'd1);
      6'd2:  u = mk(A_PT2, B_S2, 1'b1, 1'b0, 1'b1, DST_P,    2'd2);
      6'd3:  u = mk(A_P2,  B_Q2, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd4:  u = mk(A_P1,  B_Q3, 1'b0, 1'b1, 1'b0, DST_UV,   2'd0);
      6'd5:  u = mk(A_P0,  B_Q3, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd6:  u = mk(A_P2,  B_Q1, 1'b0, 1'b1, 1'b0, DST_UV,   2'd1);
      6'd7:  u = mk(A_P1,  B_Q1, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd8:  u = mk(A_P0,  B_Q2, 1'b0, 1'b1, 1'b0, DST_UV,   2'd2);
      6'd9:  u = mk(A_UV2, B_Q2, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd10: u = mk(A_UV1, B_Q3, 1'b0, 1'b1, 1'b0, DST_UUV,  2'd0);
      6'd11: u = mk(A_UV0, B_Q3, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd12: u = mk(A_UV2, B_Q1, 1'b0, 1'b1, 1'b0, DST_UUV,  2'd1);
      6'd13: u = mk(A_UV1, B_Q1, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd14: u = mk(A_UV0, B_Q2, 1'b0, 1'b1, 1'b0, DST_UUV,  2'd2);
      6'd15: u = mk(A_UV0, B_Q0, 1'b0, 1'b0, 1'b1, DST_PT,   2'd0);
      6'd16: u = mk(A_UV1, B_Q0, 1'b0, 1'b0, 1'b1, DST_PT,   2'd1);
      6'd17: u = mk(A_UV2, B_Q0, 1'b0, 1'b0, 1'b1, DST_PT,   2'd2);
      6'd18: u = mk(A_Q0,  B_C0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd19: u = mk(A_Q1,  B_C1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd20: u = mk(A_Q2,  B_C2, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd21: u = mk(A_Q3,  B_C3, 1'b0, 1'b1, 1'b0, DST_R,    2'd0);
      6'd22: u = mk(A_Q0,  B_C1, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd23: u = mk(A_Q1,  B_C0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd24: u = mk(A_Q2,  B_C3, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd25: u = mk(A_Q3,  B_C2, 1'b0, 1'b1, 1'b0, DST_R,    2'd1);
      6'd26: u = mk(A_Q0,  B_C2, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd27: u = mk(A_Q1,  B_C3, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd28: u = mk(A_Q2,  B_C0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd29: u = mk(A_Q3,  B_C1, 1'b0, 1'b0, 1'b0, DST_R,    2'd2);
      6'd30: u = mk(A_Q0,  B_C3, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd31: u = mk(A_Q1,  B_C2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd32: u = mk(A_Q2,  B_C1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd33: u = mk(A_Q3,  B_C0, 1'b0, 1'b0, 1'b0, DST_R,    2'd3);
      default: u = mk(A_PT0, B_S0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
    endcase
    return u;
  endfunction

  // {overflow, value}
  function automatic logic [PT_W:0] sat48(input logic signed [ACC_W-1:0] x);
    logic [PT_W:0] r;
    if (x > P48_MAX) begin
      r = {1'b1, P48_MAX[PT_W-1:0]};
    end else if (x < P48_MIN) begin
      r = {1'b1, P48_MIN[PT_W-1:0]};
    end else begin
      r = {1'b0, x[PT_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [Q_W:0] sat32(input logic signed [ACC_W-1:0] x);
    logic [Q_W:0] r;
    if (x > Q32_MAX) begin
      r = {1'b1, Q32_MAX[Q_W-1:0]};
    end else if (x < Q32_MIN) begin
      r = {1'b1, Q32_MIN[Q_W-1:0]};
    end else begin
      r = {1'b0, x[Q_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] r;
    r = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    return r;
  endfunction

endpackage

// File: hw/rtl/trs_mul.sv
// Shared fixed-point multiplier: floor(a * b / 2^sh), sh = 24 or 30.
// Two partial products, low word then high word. Depends on trs_pkg.
module trs_mul (
  input  logic              clk,
  input  logic              rst,
  input  trs_pkg::mul_req_t req,
  output trs_pkg::mul_rsp_t rsp
);
  import trs_pkg::*;

  logic signed [64:0]       lo;
  logic signed [ACC_W-1:0]  lo_sh;
  logic signed [ACC_W-1:0]  lo_r;
  logic signed [23:0]       ah_r;
  logic signed [Q_W-1:0]    b_r;
  logic                     sh24_r;
  logic                     busy;
  logic signed [55:0]       hi;
  logic signed [ACC_W-1:0]  hi_ext;
  logic signed [ACC_W-1:0]  hi_sh;
  logic signed [ACC_W-1:0]  m;
  logic                     done;

  always_comb begin
    lo     = $signed({1'b0, req.a[31:0]}) * req.b;
    lo_sh  = req.sh24 ? ACC_W'(lo >>> 24) : ACC_W'(lo >>> 30);
    hi     = ah_r * b_r;
    hi_ext = ACC_W'(hi);
    hi_sh  = sh24_r ? (hi_ext <<< 8) : (hi_ext <<< 2);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      lo_r   <= lo_sh;
      ah_r   <= req.a[OPA_W-1:32];
      b_r    <= req.b;
      sh24_r <= req.sh24;
    end
    if (busy) begin
      m <= hi_sh + lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= req.start;
      done <= busy;
    end
  end

  assign rsp.done = done;
  assign rsp.m    = m;

endmodule

// File: hw/rtl/trs_regs.sv
// Configuration register file: the abnormal limit behind an APB-style port.
// Depends on trs_pkg.
module trs_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [0:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [trs_pkg::LIM_W-1:0]  limit
);
  import trs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_LIMIT_ADDR) begin
      limit <= pwdata[LIM_W-1:0];
    end
  end

  assign prdata = (paddr == REG_LIMIT_ADDR) ? {{(32-LIM_W){1'b0}}, limit} : 32'd0;
  assign pready = 1'b1;

endmodule

// File: hw/rtl/trs_hierarchy_point_transform_core.sv
// Top level of the hierarchy point transform core: sequencer and datapath registers.
// Depends on trs_pkg, trs_mul and trs_regs.
//
// A start beat loads the local point. Each transform beat then runs 34 multiply steps
// on the one shared multiplier, each issued, then waiting for its two partial products
// and a write-back, so the next beat after a transform beat is taken only once all
// steps are done; a beat marked last then passes through S_FIN to form the result.
// Item ready is low while a transform runs. A finished result waits in its output
// register while the next item is taken.
module trs_hierarchy_point_transform_core #(
  parameter int MAX_CHAIN_DEPTH = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  trs_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output trs_pkg::result_t                result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [0:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import trs_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_CHAIN_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]               state;
  logic [STEP_W-1:0]        step;
  logic [DEPTH_W-1:0]       depth;
  logic                     ovf;
  logic                     force_bad;
  logic                     last_q;
  logic signed [PT_W-1:0]   pt [3];
  logic signed [Q_W-1:0]    rot [4];
  item_t                    item_q;
  logic signed [PT_W-1:0]   p [3];
  logic signed [OPA_W-1:0]  uv [3];
  logic signed [OPA_W-1:0]  uuv [3];
  logic signed [Q_W-1:0]    rr [4];
  logic signed [ACC_W-1:0]  acc;
  logic [LIM_W-1:0]         limit;

  uop_t                     uop;
  mul_req_t                 mreq;
  mul_rsp_t                 mrsp;
  logic signed [OPA_W-1:0]  opa;
  logic signed [Q_W-1:0]    opb;
  logic signed [PT_W-1:0]   tv [3];
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  rot_pre;
  logic signed [ACC_W-1:0]  xl;
  logic [PT_W:0]            sat_p;
  logic [PT_W:0]            sat_r1;
  logic [PT_W:0]            sat_x;
  logic [Q_W:0]             sat_q;
  logic                     wb_en;
  logic                     wb_ovf;
  logic [ACC_W-1:0]         plim;
  logic [ACC_W-1:0]         qlim;
  logic                     bad;
  result_t                  fin;

  trs_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  trs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  assign item_ready = (state == S_IDLE);

  always_comb begin
    uop   = uop_at(step);
    tv[0] = item_q.trans_x;
    tv[1] = item_q.trans_y;
    tv[2] = item_q.trans_z;
    case (uop.asel)
      A_PT0:   opa = OPA_W'(pt[0]);
      A_PT1:   opa = OPA_W'(pt[1]);
      A_PT2:   opa = OPA_W'(pt[2]);
      A_P0:    opa = OPA_W'(p[0]);
      A_P1:    opa = OPA_W'(p[1]);
      A_P2:    opa = OPA_W'(p[2]);
      A_UV0:   opa = uv[0];
      A_UV1:   opa = uv[1];
      A_UV2:   opa = uv[2];
      A_Q0:    opa = OPA_W'(item_q.quat_w);
      A_Q1:    opa = OPA_W'(item_q.quat_x);
      A_Q2:    opa = OPA_W'(item_q.quat_y);
      A_Q3:    opa = OPA_W'(item_q.quat_z);
      default: opa = '0;
    endcase
    case (uop.bsel)
      B_S0:    opb = item_q.scale_x;
      B_S1:    opb = item_q.scale_y;
      B_S2:    opb = item_q.scale_z;
      B_Q0:    opb = item_q.quat_w;
      B_Q1:    opb = item_q.quat_x;
      B_Q2:    opb = item_q.quat_y;
      B_Q3:    opb = item_q.quat_z;
      B_C0:    opb = rot[0];
      B_C1:    opb = rot[1];
      B_C2:    opb = rot[2];
      B_C3:    opb = rot[3];
      default: opb = '0;
    endcase
    mreq.start = (state == S_ISSUE);
    mreq.sh24  = uop.sh24;
    mreq.a     = opa;
    mreq.b     = opb;

    sum     = (uop.first ? '0 : acc) + (uop.sub ? -mrsp.m : mrsp.m);
    sat_p   = sat48(sum);
    rot_pre = ACC_W'(p[uop.didx]) + ((sum + ACC_W'(uuv[uop.didx])) <<< 1);
    sat_r1  = sat48(rot_pre);
    xl      = ACC_W'($signed(sat_r1[PT_W-1:0])) + ACC_W'(tv[uop.didx]);
    sat_x   = sat48(xl);
    sat_q   = sat32(sum);

    wb_en = (state == S_WAIT) && mrsp.done;
    case (uop.dst)
      DST_P:   wb_ovf = sat_p[PT_W];
      DST_PT:  wb_ovf = sat_r1[PT_W] | sat_x[PT_W];
      DST_R:   wb_ovf = sat_q[Q_W];
      default: wb_ovf = 1'b0;
    endcase

    plim = ACC_W'(limit) << POS_FRAC_BITS;
    qlim = ACC_W'(limit) << 30;
    bad  = force_bad || ovf
        || mag64(ACC_W'(pt[0])) > plim || mag64(ACC_W'(pt[1])) > plim
        || mag64(ACC_W'(pt[2])) > plim
        || mag64(ACC_W'(rot[0])) > qlim || mag64(ACC_W'(rot[1])) > qlim
        || mag64(ACC_W'(rot[2])) > qlim || mag64(ACC_W'(rot[3])) > qlim;

    if (bad) begin
      fin.world_x  = '0;
      fin.world_y  = '0;
      fin.world_z  = '0;
      fin.rot_w    = QUAT_ONE;
      fin.rot_x    = '0;
      fin.rot_y    = '0;
      fin.rot_z    = '0;
      fin.abnormal = 1'b1;
    end else begin
      fin.world_x  = pt[0];
      fin.world_y  = pt[1];
      fin.world_z  = pt[2];
      fin.rot_w    = rot[0];
      fin.rot_x    = rot[1];
      fin.rot_y    = rot[2];
      fin.rot_z    = rot[3];
      fin.abnormal = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
    end
    if (wb_en) begin
      acc <= sum;
      case (uop.dst)
        DST_P:   p[uop.didx]   <= sat_p[PT_W-1:0];
        DST_UV:  uv[uop.didx]  <= sum[OPA_W-1:0];
        DST_UUV: uuv[uop.didx] <= sum[OPA_W-1:0];
        DST_R:   rr[uop.didx]  <= sat_q[Q_W-1:0];
        default: ;
      endcase
    end
    if (state == S_FIN && (!result_valid || result_ready)) begin
      result <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      depth        <= '0;
      ovf          <= 1'b0;
      force_bad    <= 1'b0;
      last_q       <= 1'b0;
      result_valid <= 1'b0;
      pt[0]        <= '0;
      pt[1]        <= '0;
      pt[2]        <= '0;
      rot[0]       <= QUAT_ONE;
      rot[1]       <= '0;
      rot[2]       <= '0;
      rot[3]       <= '0;
    end else begin
      if (state == S_FIN && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.command == CMD_START) begin
              pt[0]  <= item.trans_x;
              pt[1]  <= item.trans_y;
              pt[2]  <= item.trans_z;
              rot[0] <= QUAT_ONE;
              rot[1] <= '0;
              rot[2] <= '0;
              rot[3] <= '0;
              depth  <= '0;
              ovf    <= 1'b0;
              if (item.last) begin
                force_bad <= 1'b1;
                state     <= S_FIN;
              end
            end else begin
              last_q <= item.last;
              step   <= '0;
              state  <= S_ISSUE;
              if (depth == DEPTH_W'(MAX_CHAIN_DEPTH)) begin
                ovf <= 1'b1;
              end else begin
                depth <= depth + 1'b1;
              end
            end
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mrsp.done) begin
            if (wb_ovf) begin
              ovf <= 1'b1;
            end
            if (uop.dst == DST_PT) begin
              pt[uop.didx] <= sat_x[PT_W-1:0];
            end
            if (step == STEP_W'(NUM_STEPS - 1)) begin
              rot[0] <= rr[0];
              rot[1] <= rr[1];
              rot[2] <= rr[2];
              rot[3] <= sat_q[Q_W-1:0];
              state  <= last_q ? S_FIN : S_IDLE;
            end else begin
              step  <= step + 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            force_bad    <= 1'b0;
            ovf          <= 1'b0;
            depth        <= '0;
            pt[0]        <= '0;
            pt[1]        <= '0;
            pt[2]        <= '0;
            rot[0]       <= QUAT_ONE;
            rot[1]       <= '0;
            rot[2]       <= '0;
            rot[3]       <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/trs_checker.sv
// Port-level checks of the hierarchy point transform core, bound to the top level.
// Depends on trs_pkg and the assertion macro header.
`include "trs_hierarchy_point_transform_core_macros.svh"

module trs_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input trs_pkg::item_t    item,
  input logic              result_valid,
  input logic              result_ready,
  input trs_pkg::result_t  result
);
  import trs_pkg::*;

  `TRS_ASSERT_IMP(a_abnormal_zeroed, result_valid && result.abnormal, result.world_x == 0 && result.world_y == 0 && result.world_z == 0 && result.rot_w == QUAT_ONE && result.rot_x == 0 && result.rot_y == 0 && result.rot_z == 0, "abnormal beat carries nonzero payload")
  `TRS_ASSERT_NXT(a_start_ready, item_valid && item_ready && item.command == CMD_START && !item.last, item_ready, "start beat stalled the input")
  `TRS_ASSERT_NXT(a_xform_busy, item_valid && item_ready && item.command == CMD_XFORM, !item_ready, "ready during transform")
  `TRS_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat dropped or changed")

endmodule

bind trs_hierarchy_point_transform_core trs_checker u_trs_checker (.*);

// File: tb/testbench.sv
// Testbench for trs_hierarchy_point_transform_core: chains of TRS transforms driven over
// valid/ready, results checked field by field against an in-bench fixed-point predictor.
// Depends on trs_pkg and the core RTL; the limit register is driven over the APB port.
module testbench;
  import trs_pkg::*;

  localparam int MAX_DEPTH = 512;
  localparam longint WIDE_CLAMP = 64'sd1 <<< 55;
  localparam int DRAIN_CYCLES = 120;
  localparam int N_ITEMS = 700;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  trs_hierarchy_point_transform_core #(.MAX_CHAIN_DEPTH(MAX_DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  longint acc_pt[3];
  longint acc_rot[4];
  int chain_depth;
  bit sat_seen;
  logic [LIM_W-1:0] limit_units;

  result_t world_q[$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 0;
  int hold_left = 0;
  int stall_left = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("ERROR %0t %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void clear_chain();
    acc_pt = '{0, 0, 0};
    acc_rot = '{longint'(QUAT_ONE), 0, 0, 0};
    chain_depth = 0;
    sat_seen = 0;
  endfunction

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    if (x < lo) begin
      sat_seen = 1;
      return lo;
    end
    if (x > hi) begin
      sat_seen = 1;
      return hi;
    end
    return x;
  endfunction

  // floor(a * b / 2^sh) with a split into high and low words
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    longint ah, al;
    if (a > WIDE_CLAMP) a = WIDE_CLAMP;
    if (a < -WIDE_CLAMP) a = -WIDE_CLAMP;
    ah = a >>> 32;
    al = a & 64'sh0000_0000_FFFF_FFFF;
    return (ah * b) * (64'sd1 <<< (32 - sh)) + ((al * b) >>> sh);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint mag(input longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic bit predict_world(input item_t it, output result_t r);
    longint t[3], q[4], s[3], p[3], uv[3], uuv[3], nr[4], rot, plim, qlim;
    bit bad;
    t = '{it.trans_x, it.trans_y, it.trans_z};
    q = '{it.quat_w, it.quat_x, it.quat_y, it.quat_z};
    s = '{it.scale_x, it.scale_y, it.scale_z};
    r = '0;
    if (it.command == CMD_START) begin
      clear_chain();
      acc_pt = t;
      bad = 1;
    end else begin
      if (chain_depth >= MAX_DEPTH) sat_seen = 1;
      else chain_depth++;
      for (int i = 0; i < 3; i++) p[i] = clamp(fx_mul(acc_pt[i], s[i], 24), P48_MIN, P48_MAX);
      uv[0] = fx_mul(p[2], q[2], 30) - fx_mul(p[1], q[3], 30);
      uv[1] = fx_mul(p[0], q[3], 30) - fx_mul(p[2], q[1], 30);
      uv[2] = fx_mul(p[1], q[1], 30) - fx_mul(p[0], q[2], 30);
      uuv[0] = fx_mul(uv[2], q[2], 30) - fx_mul(uv[1], q[3], 30);
      uuv[1] = fx_mul(uv[0], q[3], 30) - fx_mul(uv[2], q[1], 30);
      uuv[2] = fx_mul(uv[1], q[1], 30) - fx_mul(uv[0], q[2], 30);
      for (int i = 0; i < 3; i++) begin
        rot = clamp(p[i] + 2 * (fx_mul(uv[i], q[0], 30) + uuv[i]), P48_MIN, P48_MAX);
        acc_pt[i] = clamp(rot + t[i], P48_MIN, P48_MAX);
      end
      nr[0] = qmul(q[0], acc_rot[0]) - qmul(q[1], acc_rot[1]) - qmul(q[2], acc_rot[2])
            - qmul(q[3], acc_rot[3]);
      nr[1] = qmul(q[0], acc_rot[1]) + qmul(q[1], acc_rot[0]) + qmul(q[2], acc_rot[3])
            - qmul(q[3], acc_rot[2]);
      nr[2] = qmul(q[0], acc_rot[2]) - qmul(q[1], acc_rot[3]) + qmul(q[2], acc_rot[0])
            + qmul(q[3], acc_rot[1]);
      nr[3] = qmul(q[0], acc_rot[3]) + qmul(q[1], acc_rot[2]) - qmul(q[2], acc_rot[1])
            + qmul(q[3], acc_rot[0]);
      for (int i = 0; i < 4; i++) acc_rot[i] = clamp(nr[i], Q32_MIN, Q32_MAX);
      bad = sat_seen;
    end
    if (!it.last) return 0;
    plim = longint'(limit_units) <<< POS_FRAC_BITS;
    qlim = longint'(limit_units) <<< 30;
    for (int i = 0; i < 3; i++) if (mag(acc_pt[i]) > plim) bad = 1;
    for (int i = 0; i < 4; i++) if (mag(acc_rot[i]) > qlim) bad = 1;
    if (bad) begin
      r.rot_w = QUAT_ONE;
      r.abnormal = 1'b1;
    end else begin
      r.world_x = acc_pt[0][47:0];
      r.world_y = acc_pt[1][47:0];
      r.world_z = acc_pt[2][47:0];
      r.rot_w = acc_rot[0][31:0];
      r.rot_x = acc_rot[1][31:0];
      r.rot_y = acc_rot[2][31:0];
      r.rot_z = acc_rot[3][31:0];
    end
    clear_chain();
    return 1;
  endfunction

  // receiver: long hold-offs on request, always ready when calm, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ready = 1'b0;
      hold_left--;
    end else if (calm) begin
      result_ready = 1'b1;
    end else if (stall_left > 0) begin
      result_ready = 1'b0;
      stall_left--;
    end else begin
      result_ready = 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (world_q.size() == 0) begin
        report("unexpected result beat", result.abnormal, 0);
      end else begin
        want = world_q.pop_front();
        if (result.world_x !== want.world_x) report("world_x", result.world_x, want.world_x);
        if (result.world_y !== want.world_y) report("world_y", result.world_y, want.world_y);
        if (result.world_z !== want.world_z) report("world_z", result.world_z, want.world_z);
        if (result.rot_w !== want.rot_w) report("rot_w", result.rot_w, want.rot_w);
        if (result.rot_x !== want.rot_x) report("rot_x", result.rot_x, want.rot_x);
        if (result.rot_y !== want.rot_y) report("rot_y", result.rot_y, want.rot_y);
        if (result.rot_z !== want.rot_z) report("rot_z", result.rot_z, want.rot_z);
        if (result.abnormal !== want.abnormal)
          report("abnormal", result.abnormal, want.abnormal);
      end
    end
  end

  task automatic send_item(input item_t it);
    result_t r;
    @(negedge clk);
    if (!calm && hold_left == 0 && $urandom_range(0, 4) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    if (predict_world(it, r)) world_q = {world_q, r};
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (world_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_LIMIT_ADDR;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    limit_units = value[LIM_W-1:0];
  endtask

  task automatic read_limit();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_LIMIT_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== {9'b0, limit_units}) report("abnormal_limit readback", prdata, limit_units);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic item_t xform(input bit cmd, input bit last, input bit wild);
    item_t it;
    it.command = cmd ? CMD_XFORM : CMD_START;
    it.last = last;
    if (wild) begin
      it.trans_x = 48'({$urandom, $urandom});
      it.trans_y = 48'({$urandom, $urandom});
      it.trans_z = 48'({$urandom, $urandom});
      it.quat_w = $urandom;
      it.quat_x = $urandom;
      it.quat_y = $urandom;
      it.quat_z = $urandom;
      it.scale_x = $urandom;
      it.scale_y = $urandom;
      it.scale_z = $urandom;
    end else begin
      it.trans_x = 48'(longint'($urandom) * 4 - (64'sd1 <<< 33));
      it.trans_y = 48'(longint'($urandom) * 4 - (64'sd1 <<< 33));
      it.trans_z = 48'(longint'($urandom) * 4 - (64'sd1 <<< 33));
      it.quat_w = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      it.quat_x = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      it.quat_y = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      it.quat_z = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      it.scale_x = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      it.scale_y = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      it.scale_z = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    end
    return it;
  endfunction

  function automatic item_t ident(input bit last);
    item_t it;
    it = '0;
    it.command = CMD_XFORM;
    it.quat_w = QUAT_ONE;
    it.scale_x = 32'h0100_0000;
    it.scale_y = 32'h0100_0000;
    it.scale_z = 32'h0100_0000;
    it.last = last;
    return it;
  endfunction

  task automatic send_chain(input int len, input bit wild);
    send_item(xform(0, len == 0, wild));
    for (int i = 1; i <= len; i++) send_item(xform(1, i == len, wild));
  endtask

  task automatic test_register();
    read_limit();
    write_limit(32'd1);
    read_limit();
    write_limit(32'hFFFF_FFFF);
    read_limit();
    write_limit(32'd1000000);
    read_limit();
  endtask

  task automatic test_directed();
    item_t it;
    it = xform(0, 1, 0);
    send_item(it);
    it = '0;
    it.command = CMD_START;
    send_item(it);
    send_item(ident(1));
    it = xform(0, 0, 0);
    it.trans_x = 48'sh7FFF_FFFF_FFFF;
    it.trans_y = 48'sh8000_0000_0000;
    it.trans_z = 48'sh0000_0100_0000;
    send_item(it);
    it = xform(1, 1, 0);
    it.scale_x = 32'h7FFF_FFFF;
    it.scale_y = 32'h8000_0000;
    it.quat_w = 32'h7FFF_FFFF;
    it.quat_x = 32'h8000_0000;
    send_item(it);
    send_item(xform(1, 1, 0));
    send_chain(3, 0);
    send_chain(2, 1);
    it = xform(1, 1, 0);
    it.quat_w = 32'h8000_0000;
    it.quat_y = 32'h7FFF_FFFF;
    it.trans_x = 48'sh8000_0000_0000;
    send_item(it);
    drain();
    write_limit(32'd0);
    send_chain(2, 0);
    it = '0;
    send_item(it);
    send_item(ident(1));
    drain();
    write_limit(32'd8388607);
    send_chain(2, 1);
    send_chain(3, 0);
    drain();
    write_limit(32'd1000000);
  endtask

  task automatic test_depth(input int depth);
    item_t it;
    it = xform(0, 0, 0);
    send_item(it);
    for (int i = 1; i <= depth; i++) send_item(ident(i == depth));
  endtask

  task automatic test_hold_off();
    drain();
    hold_left = 600;
    repeat (5) send_chain($urandom_range(0, 2), 0);
    drain();
  endtask

  task automatic test_random();
    int phase_end;
    int next_cfg;
    next_cfg = items_sent + 300;
    phase_end = items_sent + N_ITEMS;
    while (items_sent < phase_end) begin
      if (items_sent >= phase_end - 300) calm = 1;
      if (items_sent >= next_cfg) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_limit($urandom_range(1, 8388607));
          1: write_limit(32'd8388607);
          2: write_limit($urandom_range(1, 4));
          default: write_limit(32'd1000000);
        endcase
        next_cfg = items_sent + 300;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(xform(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1))));
      end else begin
        send_chain($urandom_range(0, 5), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    limit_units = LIMIT_RESET;
    clear_chain();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_register();
    test_directed();
    test_depth(MAX_DEPTH);
    test_depth(MAX_DEPTH + 1);
    test_hold_off();
    test_random();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
